/* rtl/sfm_pkg.sv */
// Shared types and constants of the substring first-match unit.
`timescale 1ns / 1ps

package sfm_pkg;

  localparam int unsigned MaxNeedle   = 16;
  localparam int unsigned IndexBits   = 16;
  localparam int unsigned WindowDepth = MaxNeedle - 1;
  localparam int unsigned NeedleLenW  = $clog2(MaxNeedle + 1);
  localparam int unsigned NeedleIdxW  = (MaxNeedle > 1) ? $clog2(MaxNeedle) : 1;
  localparam int unsigned MatchIdxW   = 17;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNeedleLength = 2'd0,
    CfgNeedleLow    = 2'd1,
    CfgNeedleHigh   = 2'd2
  } sfm_cfg_idx_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
    logic       empty_text;
  } sfm_in_t;

  typedef struct packed {
    logic signed [MatchIdxW-1:0] match_index;
    logic                        found;
  } sfm_out_t;

  // Per-item control shared by every window cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } sfm_cell_ctrl_t;

endpackage

/* rtl/sfm_cell.sv */
// One window cell: holds a text byte, passes it on, compares it to its needle byte.
`timescale 1ns / 1ps

module sfm_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sfm_pkg::sfm_cell_ctrl_t ctrl_i,
  input  logic [7:0]            byte_i,
  input  logic [7:0]            needle_byte_i,
  input  logic                  in_use_i,
  output logic [7:0]            byte_o,
  output logic                  match_o
);
  import sfm_pkg::*;

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = 8'd0;
    end else if (ctrl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'd0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o  = byte_q;
  // a cell beyond the needle's reach always agrees
  assign match_o = !in_use_i || (byte_q == needle_byte_i);

endmodule

/* rtl/sfm_out_buf.sv */
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps

module sfm_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sfm_pkg::sfm_out_t push_item_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sfm_pkg::sfm_out_t out_item_o
);
  import sfm_pkg::*;

  logic     out_vld_q, out_vld_d;
  logic     skid_vld_q, skid_vld_d;
  sfm_out_t out_q, out_d;
  sfm_out_t skid_q, skid_d;
  logic     pop;

  assign pop = out_vld_q && out_ready_i;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (pop) begin
      if (skid_vld_q) begin
        // advance the skid entry to the head
        out_d      = skid_q;
        skid_vld_d = push_i;
        skid_d     = push_item_i;
      end else begin
        out_vld_d = push_i;
        out_d     = push_item_i;
      end
    end else if (push_i) begin
      if (!out_vld_q) begin
        out_vld_d = 1'b1;
        out_d     = push_item_i;
      end else begin
        skid_vld_d = 1'b1;
        skid_d     = push_item_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held without a head entry");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> !push_i)
    else $error("result pushed into a full buffer");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |=> out_vld_q)
    else $error("pushed result not held");

endmodule

/* rtl/substring_first_match_unit.sv */
// Top level of the substring first-match unit.
// Searches a byte stream for the first occurrence of a configured needle of up to 16 bytes
// and reports its start index, or -1 when the text ends without a match. One text byte is
// taken per clock cycle with no gaps while the output buffer has room; each result is
// registered into it. The last 15 bytes sit in a row of window cells that all compare
// against the needle in the same cycle as the new byte, so the per-byte compare sets the rate.
// A two-entry output buffer lets input continue while a result waits; input stalls only when
// both entries are full. Configuration is written through its own channel, which is always
// ready; writes take effect on the next item. No initialization sequence is needed after reset.
`timescale 1ns / 1ps

module substring_first_match_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sfm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sfm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sfm_pkg::sfm_in_t              in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sfm_pkg::sfm_out_t             out_item_o
);
  import sfm_pkg::*;

  // configuration registers
  logic [NeedleLenW-1:0] needle_len_q;
  logic [CfgDataW-1:0]   needle_low_q;
  logic [CfgDataW-1:0]   needle_high_q;

  // per-text state
  logic [IndexBits-1:0] pos_q, pos_d;
  logic                 done_q, done_d;

  logic                  accept;
  logic                  buf_full;
  logic [NeedleLenW-1:0] len_w;
  logic [MaxNeedle-1:0][7:0]   needle_w;
  logic [WindowDepth-1:0][7:0] cell_byte;
  logic [WindowDepth-1:0][7:0] cell_needle;
  logic [WindowDepth-1:0]      cell_in_use;
  logic [WindowDepth-1:0]      cell_match;
  logic [NeedleIdxW-1:0] tail_sel;
  logic                  tail_eq;
  logic                  reach_ok;
  logic                  hit;
  logic                  push;
  logic [MatchIdxW-1:0]  hit_index;
  sfm_out_t              result;
  sfm_cell_ctrl_t        cell_ctrl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_len_q  <= '0;
      needle_low_q  <= '0;
      needle_high_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgNeedleLength: needle_len_q  <= cfg_wdata_i[NeedleLenW-1:0];
        CfgNeedleLow:    needle_low_q  <= cfg_wdata_i;
        CfgNeedleHigh:   needle_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign len_w    = (needle_len_q > NeedleLenW'(MaxNeedle)) ? NeedleLenW'(MaxNeedle)
                                                            : needle_len_q;
  assign needle_w = (MaxNeedle*8)'({needle_high_q, needle_low_q});

  // line up each cell with the needle byte it must hold: cell k against byte len-2-k
  always_comb begin
    logic [NeedleLenW-1:0] sel;
    for (int k = 0; k < WindowDepth; k++) begin
      sel            = len_w - NeedleLenW'(k) - NeedleLenW'(2);
      cell_needle[k] = needle_w[sel[NeedleIdxW-1:0]];
      cell_in_use[k] = len_w >= NeedleLenW'(k + 2);
    end
  end

  assign tail_sel = NeedleIdxW'(len_w - NeedleLenW'(1));
  assign tail_eq  = (needle_w[tail_sel] == in_item_i.text_byte);

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = !buf_full;

  assign cell_ctrl.shift = accept && !in_item_i.empty_text && !in_item_i.last_byte;
  assign cell_ctrl.clear = accept && (in_item_i.empty_text || in_item_i.last_byte);

  for (genvar k = 0; k < WindowDepth; k++) begin : g_cell
    logic [7:0] byte_in;
    if (k == 0) begin : g_head
      assign byte_in = in_item_i.text_byte;
    end else begin : g_link
      assign byte_in = cell_byte[k-1];
    end
    sfm_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (cell_ctrl),
      .byte_i        (byte_in),
      .needle_byte_i (cell_needle[k]),
      .in_use_i      (cell_in_use[k]),
      .byte_o        (cell_byte[k]),
      .match_o       (cell_match[k])
    );
  end

  // enough bytes seen for the alignment ending at this byte
  assign reach_ok  = ({1'b0, pos_q} + (IndexBits+1)'(1)) >= (IndexBits+1)'(len_w);
  assign hit_index = MatchIdxW'(pos_q) + MatchIdxW'(1) - MatchIdxW'(len_w);

  always_comb begin
    hit         = 1'b0;
    push        = 1'b0;
    result      = '0;
    pos_d       = pos_q;
    done_d      = done_q;
    if (accept) begin
      if (in_item_i.empty_text) begin
        push   = 1'b1;
        result.match_index = (len_w == '0) ? '0 : '1;
        result.found       = (len_w == '0);
        pos_d  = '0;
        done_d = 1'b0;
      end else begin
        if (!done_q) begin
          if (len_w == '0) begin
            hit = 1'b1;
            result.match_index = '0;
          end else if (reach_ok && tail_eq && (&cell_match)) begin
            hit = 1'b1;
            result.match_index = hit_index;
          end
          if (hit) begin
            push         = 1'b1;
            result.found = 1'b1;
          end else if (in_item_i.last_byte) begin
            push               = 1'b1;
            result.match_index = '1;
            result.found       = 1'b0;
          end
        end
        if (in_item_i.last_byte) begin
          pos_d  = '0;
          done_d = 1'b0;
        end else begin
          done_d = done_q || hit;
          if (pos_q != '1) begin
            pos_d = pos_q + IndexBits'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      done_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      done_q <= done_d;
    end
  end

  sfm_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  a_done_after_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (pos_q != '0))
    else $error("search marked done before any byte");

  a_empty_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_item_i.empty_text) |=> (pos_q == '0) && !done_q)
    else $error("empty text item left text state behind");

  a_hit_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit && !in_item_i.last_byte) |=> done_q)
    else $error("match did not end the search");

  a_one_result_per_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && done_q && !in_item_i.empty_text) |-> !push)
    else $error("second result for one text");

endmodule

/* test/tb_substring_first_match_unit.sv */
// Self-checking testbench of the substring first-match unit: directed table, then random texts.
`timescale 1ns / 1ps

module tb_substring_first_match_unit;
  import sfm_pkg::*;

  localparam int unsigned SettleCycles = 4;
  localparam int unsigned CycleLimit   = 400_000;
  localparam int unsigned SegmentItems = 112;

  localparam sfm_out_t NoMatch     = '{match_index: -17'sd1, found: 1'b0};
  localparam sfm_out_t FoundAtZero = '{match_index: 17'sd0, found: 1'b1};
  localparam sfm_out_t NotTyped    = '0;

  typedef enum bit {RowItem, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    sfm_cfg_idx_e sel;
    logic [63:0]  data;
    sfm_in_t      item;
    bit           typed;
    sfm_out_t     want;
  } step_row_t;

  localparam int unsigned NumRows = 24;
  localparam step_row_t DirectedRows [NumRows] = '{
    '{RowItem, CfgNeedleLength, 64'h0, '{8'h00, 1'b0, 1'b0}, 1'b1, FoundAtZero},
    '{RowItem, CfgNeedleLength, 64'h0, '{8'hFF, 1'b1, 1'b0}, 1'b0, NotTyped},
    '{RowItem, CfgNeedleLength, 64'h0, '{8'hA5, 1'b1, 1'b1}, 1'b1, FoundAtZero},
    '{RowCfg,  CfgNeedleLength, 64'd2, '{8'h00, 1'b0, 1'b0}, 1'b0, NotTyped},
    '{RowCfg,  CfgNeedleLow, 64'h00FF, '{8'h00, 1'b0, 1'b0}, 1'b0, NotTyped},
    '{RowItem, CfgNeedleLength, 64'h0, '{8'h5A, 1'b0, 1'b1}, 1'b1, NoMatch},
    '{RowItem, CfgNeedleLength, 64'h0, '{8'h00, 1'b0, 1'b0}, 1'b0, NotTyped},
    '{RowItem, CfgNeedleLength, 64'h0, '{8'hFF, 1'b0, 1'b0}, 1'b0, NotTyped},
    '{RowItem, CfgNeedleLength, 64'h0, '{8'h00, 1'b0, 1'b0}, 1'b0, NotTyped},
    '{RowItem, CfgNeedleLength, 64'h0, '{8'hFF, 1'b1, 1'b0}, 1'b0, NotTyped},
    '{RowItem, CfgNeedleLength, 64'h0, '{8'h01, 1'b1, 1'b0}, 1'b1, NoMatch},
    '{RowItem, CfgNeedleLength, 64'h0, '{8'hFF, 1'b0, 1'b0}, 1'b0, NotTyped},
    '{RowItem, CfgNeedleLength, 64'h0, '{8'h00, 1'b0, 1'b1}, 1'b1, NoMatch},
    '{RowItem, CfgNeedleLength, 64'h0, '{8'h00, 1'b1, 1'b0}, 1'b1, NoMatch},
    '{RowCfg,  CfgNeedleLength, 64'd31, '{8'h00, 1'b0, 1'b0}, 1'b0, NotTyped},
    '{RowCfg,  CfgNeedleLow, {64{1'b1}}, '{8'h00, 1'b0, 1'b0}, 1'b0, NotTyped},
    '{RowCfg,  CfgNeedleHigh, {64{1'b1}}, '{8'h00, 1'b0, 1'b0}, 1'b0, NotTyped},
    '{RowItem, CfgNeedleLength, 64'h0, '{8'hFF, 1'b0, 1'b0}, 1'b0, NotTyped},
    '{RowItem, CfgNeedleLength, 64'h0, '{8'hFF, 1'b1, 1'b0}, 1'b0, NotTyped},
    '{RowItem, CfgNeedleLength, 64'h0, '{8'h41, 1'b0, 1'b0}, 1'b0, NotTyped},
    // needle changes while the text is in progress
    '{RowCfg,  CfgNeedleLength, 64'd1, '{8'h00, 1'b0, 1'b0}, 1'b0, NotTyped},
    '{RowCfg,  CfgNeedleLow, 64'h41, '{8'h00, 1'b0, 1'b0}, 1'b0, NotTyped},
    '{RowItem, CfgNeedleLength, 64'h0, '{8'h41, 1'b0, 1'b0}, 1'b0, NotTyped},
    '{RowItem, CfgNeedleLength, 64'h0, '{8'h00, 1'b1, 1'b0}, 1'b0, NotTyped}
  };

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  sfm_in_t              in_item_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  sfm_out_t             out_item_o;

  substring_first_match_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the search state and the needle registers
  logic [4:0]           needle_len_reg  = '0;
  logic [63:0]          needle_low_reg  = '0;
  logic [63:0]          needle_high_reg = '0;
  logic [7:0]           seen_bytes [WindowDepth];
  logic [IndexBits-1:0] text_pos;
  bit                   text_done;

  sfm_out_t    awaited_answers [$];
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  function automatic int unsigned active_len();
    return (needle_len_reg > MaxNeedle) ? MaxNeedle : int'(needle_len_reg);
  endfunction

  function automatic logic [7:0] needle_at(int unsigned j);
    return (j < 8) ? needle_low_reg[8*j +: 8] : needle_high_reg[8*(j-8) +: 8];
  endfunction

  task automatic clear_text();
    for (int i = 0; i < WindowDepth; i++) seen_bytes[i] = 8'h00;
    text_pos  = '0;
    text_done = 1'b0;
  endtask

  initial clear_text();

  task automatic predict_search(input sfm_in_t it, output bit has_ans, output sfm_out_t ans);
    int unsigned alen;
    int unsigned w;
    bit          eq;
    alen    = active_len();
    has_ans = 1'b0;
    ans     = '0;
    if (it.empty_text) begin
      clear_text();
      ans     = (alen == 0) ? FoundAtZero : NoMatch;
      has_ans = 1'b1;
      return;
    end
    if (!text_done) begin
      if (alen == 0) begin
        ans       = FoundAtZero;
        text_done = 1'b1;
        has_ans   = 1'b1;
      end else if (int'(text_pos) + 1 >= alen) begin
        // compare the alignment that ends at this byte
        eq = (needle_at(alen - 1) == it.text_byte);
        for (int i = 0; i + 1 < alen; i++) begin
          w = alen - 2 - i;
          if (w >= WindowDepth || seen_bytes[w] != needle_at(i)) eq = 1'b0;
        end
        if (eq) begin
          ans.match_index = MatchIdxW'(int'(text_pos) + 1 - int'(alen));
          ans.found       = 1'b1;
          text_done       = 1'b1;
          has_ans         = 1'b1;
        end
      end
      if (!text_done && it.last_byte) begin
        ans     = NoMatch;
        has_ans = 1'b1;
      end
    end
    if (it.last_byte) begin
      clear_text();
      return;
    end
    for (int i = WindowDepth - 1; i > 0; i--) seen_bytes[i] = seen_bytes[i-1];
    seen_bytes[0] = it.text_byte;
    if (text_pos != {IndexBits{1'b1}}) text_pos = text_pos + 1'b1;
  endtask

  // Drop valid, wait for every answer, then let the pipeline settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input sfm_cfg_idx_e sel, input logic [63:0] data);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (sel)
      CfgNeedleLength: needle_len_reg  = data[4:0];
      CfgNeedleLow:    needle_low_reg  = data;
      CfgNeedleHigh:   needle_high_reg = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic feed_item(input sfm_in_t it, input bit typed, input sfm_out_t want);
    bit       has_ans;
    sfm_out_t ans;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_search(it, has_ans, ans);
    if (typed) awaited_answers.push_back(want);
    else if (has_ans) awaited_answers.push_back(ans);
  endtask

  task automatic run_texts(input int unsigned count);
    int unsigned sent;
    int unsigned alen;
    int unsigned tlen;
    int unsigned plant;
    int unsigned r;
    logic [4:0]  len;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [7:0]  sym_a;
    logic [7:0]  sym_b;
    logic [7:0]  b;
    sfm_in_t     text_q [$];
    sent = 0;
    case ($urandom_range(9))
      0:       len = 5'd0;
      1:       len = 5'd16;
      2:       len = 5'($urandom_range(31, 17));
      3:       len = 5'd1;
      default: len = 5'($urandom_range(6, 1));
    endcase
    r     = $urandom_range(7);
    sym_a = 8'($urandom_range(255));
    sym_b = 8'($urandom_range(255));
    lo    = {$urandom, $urandom};
    hi    = {$urandom, $urandom};
    if (r == 0) begin
      lo = '0;
      hi = '0;
    end else if (r == 1) begin
      lo = '1;
      hi = '1;
    end else if (r < 4) begin
      // two-symbol needle: plenty of partial matches
      for (int j = 0; j < 8; j++) begin
        lo[8*j +: 8] = $urandom_range(1) ? sym_a : sym_b;
        hi[8*j +: 8] = $urandom_range(1) ? sym_a : sym_b;
      end
    end
    write_reg(CfgNeedleLength, 64'(len));
    write_reg(CfgNeedleLow, lo);
    write_reg(CfgNeedleHigh, hi);
    alen = active_len();
    while (sent < count) begin
      text_q.delete();
      r = $urandom_range(19);
      if (r == 0) begin
        text_q.push_back('{8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1});
      end else begin
        tlen = ($urandom_range(9) == 0) ? $urandom_range(48, 17) : $urandom_range(16, 1);
        for (int k = 0; k < tlen; k++) begin
          b = (alen > 0 && $urandom_range(9) < 7) ? needle_at($urandom_range(alen - 1))
                                                  : 8'($urandom_range(255));
          text_q.push_back('{b, 1'(k == tlen - 1), 1'b0});
        end
        if (alen > 0 && tlen >= alen && $urandom_range(1)) begin
          plant = $urandom_range(tlen - alen);
          for (int j = 0; j < alen; j++) text_q[plant + j].text_byte = needle_at(j);
        end
        // break the text with an empty-text item
        if (r == 1) text_q[$urandom_range(tlen - 1)].empty_text = 1'b1;
      end
      if ($urandom_range(59) == 0) wait_idle();
      foreach (text_q[k]) begin
        if (sent < count) begin
          feed_item(text_q[k], 1'b0, NotTyped);
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_answers.size() == 0) begin
          $error("unexpected result: match_index %0d, found %0b",
                 out_item_o.match_index, out_item_o.found);
          fail_count++;
        end else begin
          if (out_item_o.match_index !== awaited_answers[0].match_index) begin
            $error("match_index: expected %0d, got %0d",
                   awaited_answers[0].match_index, out_item_o.match_index);
            fail_count++;
          end
          if (out_item_o.found !== awaited_answers[0].found) begin
            $error("found: expected %0b, got %0b", awaited_answers[0].found, out_item_o.found);
            fail_count++;
          end
          void'(awaited_answers.pop_front());
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NumRows; i++) begin
      if (DirectedRows[i].kind == RowCfg) write_reg(DirectedRows[i].sel, DirectedRows[i].data);
      else feed_item(DirectedRows[i].item, DirectedRows[i].typed, DirectedRows[i].want);
    end
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      for (int seg = 0; seg < 3; seg++) run_texts(SegmentItems);
    end
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
rtl/sfm_pkg.sv
rtl/sfm_cell.sv
rtl/sfm_out_buf.sv
rtl/substring_first_match_unit.sv
test/tb_substring_first_match_unit.sv
